// ===== hw/rtl/bpdlp_pkg.sv =====
// Package: shared types, constants and register codes for the button debounce block.
package bpdlp_pkg;

	localparam int NumButtons = 4;
	localparam int TimeW      = 32;
	localparam int MsW        = 16;
	localparam int ModeW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 16;

	localparam logic [CfgIdxW-1:0] CFG_ENABLE      = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_MODE_BUTTON = 2'd3;

	localparam logic             RstEnable     = 1'b1;
	localparam logic [MsW-1:0]   RstDebounce   = 16'd100;
	localparam logic [MsW-1:0]   RstLongPress  = 16'd1000;
	localparam logic [ModeW-1:0] RstModeButton = 2'd1;

	typedef struct packed {
		logic [NumButtons-1:0] levels;
		logic [TimeW-1:0]      now_ms;
	} sample_t;

	typedef struct packed {
		logic [NumButtons-1:0] press_events;
		logic                  activity;
		logic                  mode_short;
		logic                  mode_long;
	} result_t;

	typedef struct packed {
		logic pressed;
		logic accepted;
	} lane_stat_t;

endpackage

// ===== hw/rtl/bpdlp_lane.sv =====
// Per-button lane: edge detection and debounce window against the last accepted press.
module bpdlp_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          level,
	input  logic [bpdlp_pkg::TimeW-1:0]   now_ms,
	input  logic [bpdlp_pkg::MsW-1:0]     debounce_ms,
	output bpdlp_pkg::lane_stat_t         stat
);

	logic                        prev_q;
	logic [bpdlp_pkg::TimeW-1:0] last_q;
	logic [bpdlp_pkg::TimeW-1:0] elapsed;

	assign elapsed       = now_ms - last_q;
	assign stat.pressed  = ~level;
	assign stat.accepted = ~level & prev_q &
		(elapsed >= {{(bpdlp_pkg::TimeW-bpdlp_pkg::MsW){1'b0}}, debounce_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			last_q <= '0;
		end else if (step) begin
			prev_q <= level;
			if (stat.accepted) begin
				last_q <= now_ms;
			end
		end
	end

endmodule

// ===== hw/rtl/bpdlp_mode.sv =====
// Merge stage: gathers lane results and runs the mode button short/long tracker.
module bpdlp_mode (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  bpdlp_pkg::lane_stat_t           lanes [bpdlp_pkg::NumButtons],
	input  logic [bpdlp_pkg::TimeW-1:0]     now_ms,
	input  logic [bpdlp_pkg::MsW-1:0]       long_press_ms,
	input  logic [bpdlp_pkg::ModeW-1:0]     mode_button,
	output bpdlp_pkg::result_t              res
);

	logic                              tracking_q;
	logic                              fired_q;
	logic [bpdlp_pkg::TimeW-1:0]       start_q;
	logic [bpdlp_pkg::NumButtons-1:0]  press_vec;
	logic                              mode_acc;
	logic                              held;
	logic                              trk;
	logic                              fired;
	logic                              long_hit;
	logic                              short_ev;
	logic                              long_ev;
	logic [bpdlp_pkg::TimeW-1:0]       hold_time;

	always_comb begin
		press_vec = '0;
		mode_acc  = 1'b0;
		held      = 1'b0;
		for (int i = 0; i < bpdlp_pkg::NumButtons; i++) begin
			press_vec[i] = lanes[i].accepted;
			if (mode_button == bpdlp_pkg::ModeW'(i)) begin
				mode_acc = lanes[i].accepted;
				held     = lanes[i].pressed;
			end
		end
	end

	assign hold_time = now_ms - start_q;
	// a fresh press has zero hold time
	assign long_hit  = mode_acc ? (long_press_ms == '0) :
		(hold_time >= {{(bpdlp_pkg::TimeW-bpdlp_pkg::MsW){1'b0}}, long_press_ms});
	assign trk       = tracking_q | mode_acc;
	assign fired     = fired_q & ~mode_acc;
	assign short_ev  = trk & ~held & ~fired;
	assign long_ev   = trk & held & ~fired & long_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			fired_q    <= 1'b0;
			start_q    <= '0;
		end else if (step) begin
			if (mode_acc) begin
				start_q <= now_ms;
			end
			if (trk && !held) begin
				tracking_q <= 1'b0;
				fired_q    <= 1'b0;
			end else begin
				tracking_q <= trk;
				fired_q    <= fired | long_ev;
			end
		end
	end

	assign res.press_events = press_vec;
	assign res.activity     = |press_vec;
	assign res.mode_short   = short_ev;
	assign res.mode_long    = long_ev;

endmodule

// ===== hw/rtl/button_press_debounce_long_press_top.sv =====
// Top level: config registers, button lanes, merge stage and output register.
//
// Takes one poll sample per clock and returns one result beat per sample, in the cycle
// after it is accepted; a sample may follow every cycle. All per-button work happens in
// parallel lanes and the mode tracker in the same cycle, so the throughput is set only by
// the output register: a new sample is taken whenever that register is empty or its beat
// is being taken. With enable low, samples still produce a beat, with every field zero,
// and no state moves.
module button_press_debounce_long_press_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpdlp_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [bpdlp_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  bpdlp_pkg::sample_t                sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output bpdlp_pkg::result_t                result
);

	logic                            enable_q;
	logic [bpdlp_pkg::MsW-1:0]       debounce_q;
	logic [bpdlp_pkg::MsW-1:0]       long_press_q;
	logic [bpdlp_pkg::ModeW-1:0]     mode_button_q;
	logic                            result_valid_q;
	bpdlp_pkg::result_t              result_q;
	bpdlp_pkg::result_t              res;
	bpdlp_pkg::lane_stat_t           lanes [bpdlp_pkg::NumButtons];
	logic                            load;
	logic                            step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= bpdlp_pkg::RstEnable;
			debounce_q    <= bpdlp_pkg::RstDebounce;
			long_press_q  <= bpdlp_pkg::RstLongPress;
			mode_button_q <= bpdlp_pkg::RstModeButton;
		end else if (cfg_we) begin
			case (cfg_index)
				bpdlp_pkg::CFG_ENABLE:      enable_q      <= cfg_data[0];
				bpdlp_pkg::CFG_DEBOUNCE:    debounce_q    <= cfg_data;
				bpdlp_pkg::CFG_LONG_PRESS:  long_press_q  <= cfg_data;
				bpdlp_pkg::CFG_MODE_BUTTON: mode_button_q <= cfg_data[bpdlp_pkg::ModeW-1:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = result_valid_q & result_stall;
	assign load         = sample_valid & ~sample_stall;
	assign step         = load & enable_q;

	for (genvar g = 0; g < bpdlp_pkg::NumButtons; g++) begin : g_lane
		bpdlp_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (step),
			.level       (sample.levels[g]),
			.now_ms      (sample.now_ms),
			.debounce_ms (debounce_q),
			.stat        (lanes[g])
		);
	end

	bpdlp_mode u_mode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.lanes         (lanes),
		.now_ms        (sample.now_ms),
		.long_press_ms (long_press_q),
		.mode_button   (mode_button_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= enable_q ? res : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/bpdlp_checker.sv =====
// Port checker for the button debounce top level, with its bind.
module bpdlp_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  bpdlp_pkg::result_t   result
);

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("sample stalled with empty output");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> result_valid)
		else $error("accepted sample gave no result beat");

	a_activity: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.activity == (|result.press_events)))
		else $error("activity disagrees with press events");

	a_short_long: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.mode_short && result.mode_long))
		else $error("short and long events in one beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

endmodule

bind button_press_debounce_long_press_top bpdlp_checker u_bpdlp_checker (.*);

// ===== tb/sv/button_press_debounce_long_press_top_tb.sv =====
// Testbench for button_press_debounce_long_press_top: predicts every result beat and checks it.
`timescale 1ns / 1ps

module button_press_debounce_long_press_top_tb;

	localparam int StallLimit = 5000;

	logic                                  clk;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_we = 1'b0;
	logic [bpdlp_pkg::CfgIdxW-1:0]         cfg_index = bpdlp_pkg::CFG_ENABLE;
	logic [bpdlp_pkg::CfgDataW-1:0]        cfg_data = '0;
	logic                                  sample_valid = 1'b0;
	logic                                  sample_stall;
	bpdlp_pkg::sample_t                    sample = '0;
	logic                                  result_valid;
	logic                                  result_stall = 1'b0;
	bpdlp_pkg::result_t                    result;

	// predictor state and its copy of the registers
	logic                                  cfg_enable;
	logic [bpdlp_pkg::MsW-1:0]             cfg_debounce;
	logic [bpdlp_pkg::MsW-1:0]             cfg_long;
	logic [bpdlp_pkg::ModeW-1:0]           cfg_mode;
	logic [bpdlp_pkg::NumButtons-1:0]      prev_levels;
	logic [bpdlp_pkg::TimeW-1:0]           last_press_ms [bpdlp_pkg::NumButtons];
	logic                                  tracking;
	logic [bpdlp_pkg::TimeW-1:0]           track_start_ms;
	logic                                  long_done;

	bpdlp_pkg::sample_t poll_queue [$];
	bpdlp_pkg::result_t predicted_events [$];
	bpdlp_pkg::result_t want_result;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit send_pause = 1'b0;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int press_count = 0;
	int short_count = 0;
	int long_count = 0;

	logic [bpdlp_pkg::TimeW-1:0]      stim_ms = '0;
	logic [bpdlp_pkg::NumButtons-1:0] stim_levels = '1;

	button_press_debounce_long_press_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bpdlp_pkg::result_t debounce_predict(bpdlp_pkg::sample_t s);
		bpdlp_pkg::result_t          r;
		logic [bpdlp_pkg::TimeW-1:0] since;
		logic                        held;
		r = '0;
		if (!cfg_enable)
			return r;
		for (int i = 0; i < bpdlp_pkg::NumButtons; i++) begin
			if (!s.levels[i] && prev_levels[i]) begin
				since = s.now_ms - last_press_ms[i];
				if (since >= bpdlp_pkg::TimeW'(cfg_debounce)) begin
					last_press_ms[i] = s.now_ms;
					r.press_events[i] = 1'b1;
					if (i == int'(cfg_mode)) begin
						tracking = 1'b1;
						track_start_ms = s.now_ms;
						long_done = 1'b0;
					end
				end
			end
		end
		if (tracking) begin
			held = (int'(cfg_mode) < bpdlp_pkg::NumButtons) && !s.levels[cfg_mode];
			since = s.now_ms - track_start_ms;
			if (!held) begin
				r.mode_short = !long_done;
				tracking = 1'b0;
				long_done = 1'b0;
			end else if (!long_done && since >= bpdlp_pkg::TimeW'(cfg_long)) begin
				r.mode_long = 1'b1;
				long_done = 1'b1;
			end
		end
		prev_levels = s.levels;
		r.activity = |r.press_events;
		return r;
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && !sample_stall) begin
				predicted_events.push_back(debounce_predict(sample));
				beats_in++;
			end
			if (!sample_valid || !sample_stall) begin
				if (poll_queue.size() != 0 && !send_pause &&
				    $urandom_range(99) >= send_idle_pct) begin
					sample_valid <= 1'b1;
					sample <= poll_queue.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				beats_out++;
				if (predicted_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: events %h act %b short %b long %b",
							result.press_events, result.activity, result.mode_short,
							result.mode_long);
				end else begin
					want_result = predicted_events.pop_front();
					if (result.press_events !== want_result.press_events ||
					    result.activity !== want_result.activity ||
					    result.mode_short !== want_result.mode_short ||
					    result.mode_long !== want_result.mode_long) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at beat %0d: exp %h/%b/%b/%b got %h/%b/%b/%b",
								beats_out, want_result.press_events, want_result.activity,
								want_result.mode_short, want_result.mode_long,
								result.press_events, result.activity, result.mode_short,
								result.mode_long);
					end
					if (want_result.activity)
						press_count++;
					if (want_result.mode_short)
						short_count++;
					if (want_result.mode_long)
						long_count++;
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= 300;
				result_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
		    (poll_queue.size() == 0 && !sample_valid && predicted_events.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("timeout: no beat moved for %0d cycles", idle_cycles);
			$display("button_press_debounce_long_press_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [bpdlp_pkg::CfgIdxW-1:0] idx,
	                         input logic [bpdlp_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bpdlp_pkg::CFG_ENABLE: cfg_enable = val[0];
			bpdlp_pkg::CFG_DEBOUNCE: cfg_debounce = val;
			bpdlp_pkg::CFG_LONG_PRESS: cfg_long = val;
			bpdlp_pkg::CFG_MODE_BUTTON: cfg_mode = val[bpdlp_pkg::ModeW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic en, input logic [bpdlp_pkg::MsW-1:0] deb,
	                          input logic [bpdlp_pkg::MsW-1:0] lng,
	                          input logic [bpdlp_pkg::ModeW-1:0] mode);
		write_reg(bpdlp_pkg::CFG_ENABLE, bpdlp_pkg::CfgDataW'(en));
		write_reg(bpdlp_pkg::CFG_DEBOUNCE, deb);
		write_reg(bpdlp_pkg::CFG_LONG_PRESS, lng);
		write_reg(bpdlp_pkg::CFG_MODE_BUTTON, bpdlp_pkg::CfgDataW'(mode));
	endtask

	task automatic push(input logic [bpdlp_pkg::NumButtons-1:0] lv,
	                    input logic [bpdlp_pkg::TimeW-1:0] ms);
		bpdlp_pkg::sample_t s;
		s.levels = lv;
		s.now_ms = ms;
		poll_queue.push_back(s);
	endtask

	task automatic drain();
		while (poll_queue.size() != 0 || sample_valid || predicted_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// button traffic: mostly toggles with advancing time, now and then a jump or noise
	task automatic push_random(input int n, input int unsigned max_step);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 4)
				stim_ms = $urandom;
			else
				stim_ms = stim_ms + $urandom_range(max_step);
			if (r >= 4 && r < 9) begin
				stim_levels = bpdlp_pkg::NumButtons'($urandom);
			end else begin
				for (int b = 0; b < bpdlp_pkg::NumButtons; b++)
					if ($urandom_range(99) < 20)
						stim_levels[b] = ~stim_levels[b];
			end
			push(stim_levels, stim_ms);
		end
	endtask

	initial begin
		cfg_enable = bpdlp_pkg::RstEnable;
		cfg_debounce = bpdlp_pkg::RstDebounce;
		cfg_long = bpdlp_pkg::RstLongPress;
		cfg_mode = bpdlp_pkg::RstModeButton;
		prev_levels = '1;
		foreach (last_press_ms[i])
			last_press_ms[i] = '0;
		tracking = 1'b0;
		track_start_ms = '0;
		long_done = 1'b0;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings
		push(4'hF, 32'd0);
		push(4'h0, 32'd50);          // press inside window right after reset
		push(4'hF, 32'd60);
		push(4'hE, 32'd100);
		push(4'hC, 32'd150);         // mode press, tracking starts
		push(4'hC, 32'd1149);
		push(4'hC, 32'd1150);        // long press
		push(4'hC, 32'd2000);
		push(4'hE, 32'd2010);        // release after long, no short
		push(4'hC, 32'd2050);
		push(4'hE, 32'd2100);        // short press
		push(4'hC, 32'd2140);        // mode press rejected by debounce
		push(4'hF, 32'd2200);
		push(4'h7, 32'hFFFF_FFF0);
		push(4'hF, 32'hFFFF_FFF8);
		push(4'h7, 32'h0000_0050);   // rejected across the time wrap
		push(4'hF, 32'h0000_0060);
		push(4'h0, 32'hFFFF_FFFF);
		push(4'hF, 32'h0000_0000);
		drain();
		set_config(1'b1, 16'd0, 16'd0, 2'd2);
		push(4'hB, 32'd5);           // zero hold time: long in the press sample
		push(4'hF, 32'd6);
		drain();
		write_reg(bpdlp_pkg::CFG_LONG_PRESS, 16'd1000);
		push(4'hB, 32'd10);
		drain();
		write_reg(bpdlp_pkg::CFG_MODE_BUTTON, 16'd0);   // tracker now reads a released button
		push(4'hB, 32'd20);
		drain();
		write_reg(bpdlp_pkg::CFG_ENABLE, 16'd0);
		push(4'h0, 32'd500);
		push(4'hF, 32'd600);
		drain();

		// random phases
		set_config(1'b1, 16'd100, 16'd500, 2'd1);
		send_idle_pct = 0;
		stall_pct = 0;
		push_random(130, 300);
		drain();

		set_config(1'b1, 16'd0, 16'd0, 2'd3);
		send_idle_pct = 64;
		stall_pct = 0;
		push_random(130, 200);
		drain();

		set_config(1'b1, 16'hFFFF, 16'hFFFF, 2'd0);
		send_idle_pct = 0;
		stall_pct = 64;
		push_random(130, 5000);
		drain();

		set_config(1'b1, 16'd40, 16'd250, 2'd2);
		send_idle_pct = 7;
		stall_pct = 7;
		push_random(130, 150);
		hold_req = ~hold_req;   // long receiver hold-off while samples keep coming
		while (poll_queue.size() > 65)
			@(negedge clk);
		send_pause = 1'b1;
		while (sample_valid || predicted_events.size() != 0)
			@(negedge clk);
		send_pause = 1'b0;
		drain();

		write_reg(bpdlp_pkg::CFG_ENABLE, 16'd0);
		send_idle_pct = 0;
		stall_pct = 0;
		push_random(40, 200);
		drain();
		set_config(1'b1, 16'($urandom_range(200)), 16'($urandom_range(800)),
			2'($urandom_range(3)));
		send_idle_pct = 30;
		stall_pct = 30;
		push_random(130, 250);
		drain();

		repeat (4) @(negedge clk);
		$display("Ran %0d samples over all register extremes and idle mixes, %0d result beats",
			beats_in, beats_out);
		$display("Seen %0d samples with presses, %0d short and %0d long mode events, %0d bad",
			press_count, short_count, long_count, mismatches);
		if (mismatches == 0 && predicted_events.size() == 0) begin
			$display("button_press_debounce_long_press_top test passed");
		end else begin
			$display("button_press_debounce_long_press_top test failed");
		end
		$finish;
	end

endmodule
